@@ design/grg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grg_pkg: shared types and constants of the room grower
// Beat structs, configuration indexes, command and status groups.
// ----------------------------------------------------------------------------
package grg_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_W = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_H = 1'd1;

  localparam logic [CFG_DATA_W-1:0] ACTIVE_RST = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       traversable;
  } in_beat_t;

  typedef struct packed {
    logic       room_ok;
    logic [6:0] room_width;
    logic [6:0] room_height;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic ld_wr;
    logic origin;
    logic square;
    logic widen;
    logic height;
    logic clear;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic origin_ok;
    logic sq_go;
    logic wd_go;
    logic ht_go;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

@@ design/grg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grg_ctrl: sequencer of the room grower
// Steps one item through load, origin check, growth phases and clearing.
// ----------------------------------------------------------------------------
module grg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          idle,
  output grg_pkg::cmd_t cmd,
  input  grg_pkg::sts_t sts
);
  import grg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LDWR = 3'd1;
  localparam logic [2:0] ST_ORIG = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_WIDE = 3'd4;
  localparam logic [2:0] ST_HGT  = 3'd5;
  localparam logic [2:0] ST_CLR  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = (in_opcode == OP_BUILD) ? ST_ORIG : ST_LDWR;
        end
      end
      ST_LDWR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_ORIG: begin
        cmd.origin = 1'b1;
        state_nxt  = sts.origin_ok ? ST_SQR : ST_DONE;
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        if (!sts.sq_go) begin
          state_nxt = ST_WIDE;
        end
      end
      ST_WIDE: begin
        cmd.widen = 1'b1;
        if (!sts.wd_go) begin
          state_nxt = ST_HGT;
        end
      end
      ST_HGT: begin
        cmd.height = 1'b1;
        if (!sts.ht_go) begin
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/grg_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grg_dpath: row store, growth registers and result register
// One free bit per cell (open and not assigned), one row read per cycle.
// ----------------------------------------------------------------------------
module grg_dpath #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  grg_pkg::cmd_t                      cmd,
  output grg_pkg::sts_t                      sts,
  input  grg_pkg::in_beat_t                  in_data,
  input  logic                               cfg_we,
  input  logic [grg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [grg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_ready,
  output grg_pkg::out_beat_t                 out_data
);
  import grg_pkg::*;

  localparam int AW   = $clog2(GRID_H);
  localparam int XW   = $clog2(GRID_W);
  localparam int WW   = $clog2(GRID_W + 1);
  localparam int HW   = $clog2(GRID_H + 1);
  localparam int YCW  = $clog2(GRID_H + 64);
  localparam int CMPW = (YCW > CFG_DATA_W) ? YCW : CFG_DATA_W;

  function automatic logic [GRID_W-1:0] pmask(input logic [WW-1:0] n);
    logic [GRID_W-1:0] m;
    for (int i = 0; i < GRID_W; i++) begin
      m[i] = (n > WW'(i));
    end
    return m;
  endfunction

  // configuration
  logic [CFG_DATA_W-1:0] active_w_r, active_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_w_r <= ACTIVE_RST;
      active_h_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_ACTIVE_W) begin
        active_w_r <= cfg_wdata;
      end
      if (cfg_idx == REG_ACTIVE_H) begin
        active_h_r <= cfg_wdata;
      end
    end
  end

  // item registers
  logic [5:0]        ox_r;
  logic [YCW-1:0]    oy_r, y_r, y_nxt;
  logic              tr_r;
  logic [GRID_W-1:0] acc_r;
  logic [WW-1:0]     w_r;
  logic [HW-1:0]     h_r;
  logic              ok_r;

  // row store
  logic [GRID_W-1:0] mem [GRID_H];
  logic              vld_r [GRID_H];
  logic [GRID_W-1:0] rd_row_r;
  logic              rd_vld_r;
  logic              mem_we;
  logic [AW-1:0]     wa, ra;
  logic [GRID_W-1:0] wd;

  assign ra = y_nxt[AW-1:0];
  assign wa = y_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= wd;
    end
    if (mem_we && wa == ra) begin
      rd_row_r <= wd;
    end else begin
      rd_row_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GRID_H; i++) begin
        vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[wa] <= 1'b1;
      end
      rd_vld_r <= vld_r[ra] | (mem_we && wa == ra);
    end
  end

  // row views
  logic [GRID_W-1:0] row_base, acmask, row_eff, shifted, newacc;
  logic [GRID_W-1:0] pm_next, pm_w, cmask, ld_bit;
  logic              row_in, ld_ok;

  assign row_base = rd_vld_r ? rd_row_r : '0;

  always_comb begin
    for (int i = 0; i < GRID_W; i++) begin
      acmask[i] = (active_w_r > CFG_DATA_W'(i));
    end
  end

  assign row_in  = (y_r < YCW'(GRID_H)) && (CMPW'(y_r) < CMPW'(active_h_r));
  assign row_eff = row_base & acmask & {GRID_W{row_in}};
  assign shifted = row_eff >> ox_r;
  assign newacc  = acc_r & shifted;
  assign pm_next = pmask(w_r + WW'(1));
  assign pm_w    = pmask(w_r);
  assign cmask   = pm_w << ox_r;
  assign ld_bit  = GRID_W'(1) << ox_r;
  assign ld_ok   = (7'(ox_r) < 7'(GRID_W)) && (y_r < YCW'(GRID_H));

  assign sts.origin_ok = shifted[0];
  assign sts.sq_go     = (w_r < WW'(GRID_W)) && ((newacc & pm_next) == pm_next);
  assign sts.wd_go     = (w_r < WW'(GRID_W)) && acc_r[w_r[XW-1:0]];
  assign sts.ht_go     = ((shifted & pm_w) == pm_w);
  assign sts.clr_last  = ((y_r + YCW'(1)) == (oy_r + YCW'(h_r)));
  assign sts.out_free  = !out_valid || out_ready;

  // store writes and next row
  always_comb begin
    mem_we = 1'b0;
    wd     = row_base;
    y_nxt  = y_r;
    priority if (cmd.accept) begin
      y_nxt = YCW'(in_data.cell_y);
    end else if (cmd.ld_wr) begin
      mem_we = ld_ok;
      wd     = tr_r ? (row_base | ld_bit) : (row_base & ~ld_bit);
    end else if (cmd.origin) begin
      if (sts.origin_ok) begin
        y_nxt = y_r + YCW'(1);
      end
    end else if (cmd.square) begin
      if (sts.sq_go) begin
        y_nxt = y_r + YCW'(1);
      end
    end else if (cmd.height) begin
      y_nxt = sts.ht_go ? (y_r + YCW'(1)) : oy_r;
    end else if (cmd.clear) begin
      mem_we = 1'b1;
      wd     = row_base & ~cmask;
      y_nxt  = y_r + YCW'(1);
    end else begin
      y_nxt = y_r;
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    if (cmd.accept) begin
      ox_r <= in_data.cell_x;
      oy_r <= YCW'(in_data.cell_y);
      tr_r <= in_data.traversable;
    end
    if (cmd.ld_wr) begin
      ok_r <= 1'b1;
      w_r  <= '0;
      h_r  <= '0;
    end
    if (cmd.origin) begin
      ok_r  <= sts.origin_ok;
      acc_r <= shifted;
      w_r   <= sts.origin_ok ? WW'(1) : '0;
      h_r   <= sts.origin_ok ? HW'(1) : '0;
    end
    if (cmd.square && sts.sq_go) begin
      acc_r <= newacc;
      w_r   <= w_r + WW'(1);
      h_r   <= h_r + HW'(1);
    end
    if (cmd.widen && sts.wd_go) begin
      w_r <= w_r + WW'(1);
    end
    if (cmd.height && sts.ht_go) begin
      h_r <= h_r + HW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.room_ok     <= ok_r;
      out_data.room_width  <= 7'(w_r);
      out_data.room_height <= 7'(h_r);
    end
  end

endmodule

@@ design/greedy_rect_room_grower_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_rect_room_grower_top: greedy rectangular room grower
// Holds a cell grid, loads cells and grows rooms from an origin cell.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | beat / data
//   ---------+------------------------+---------------------------------------
//   in_      | in_valid / in_ready    | in_beat_t: opcode, cell_x, cell_y, trav.
//   out_     | out_valid / out_ready  | out_beat_t: room_ok, width, height
//   cfg_     | cfg_we (no wait)       | cfg_idx selects width/height, cfg_wdata
//
// Steps: a load is accept with row read, row write, result load; a build is
// accept, origin check, square, widen, height, assign pass, result load; a
// failed build ends after the origin check. The row store gives one row per
// cycle; the square and height phases and the assign pass walk it by rows.
// Reset: synchronous, active low; clears every cell through per-row valid
// flags at once, so no clearing pass runs and the block is ready right away.
// Stalls: a finished result waits in the output register; the next item is
// accepted meanwhile, and only its own result waits for the register.
// ----------------------------------------------------------------------------
module greedy_rect_room_grower_top #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  grg_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output grg_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [grg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [grg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import grg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;

  // sequencer: one item at a time, steps the datapath by command
  grg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .idle      (idle),
    .cmd       (cmd),
    .sts       (sts)
  );

  // row store, growth registers, result register
  grg_dpath #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // take a beat only between items
  assign in_ready = idle;

  // a failed build carries no size
  a_fail_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.room_ok) |->
      (out_data.room_width == 7'd0 && out_data.room_height == 7'd0))
    else $error("failed build reports a nonzero size");

  // a built room has both sides or neither (loads report zero)
  a_room_sides: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.room_ok) |->
      ((out_data.room_width == 7'd0) == (out_data.room_height == 7'd0)))
    else $error("room with one side zero");

  // after an accepted beat the block is still busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted back to back");

  // every loaded result shows up on the output
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result register not filled");

endmodule
